// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: command codes,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0]  CODE_LF    = 8'd10;
  localparam logic [7:0]  CODE_CR    = 8'd13;
  localparam logic [7:0]  CODE_SPACE = 8'h20;
  localparam logic [15:0] RESET_CELL = 16'h0F20;

  localparam logic [3:0] FG_RESET = 4'hF;
  localparam logic [3:0] BG_RESET = 4'h0;

  // register index, taken from paddr bit 2
  localparam logic REG_FG_COLOR = 1'b0;
  localparam logic REG_BG_COLOR = 1'b1;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCROLL,
    S_CLEAR
  } state_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CHAR,
    WR_INIT,
    WR_BLANK,
    WR_COPY
  } wr_sel_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_POS,
    RD_COPY
  } rd_sel_e;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_PUT,
    CUR_MOVE,
    CUR_HOME
  } cur_op_e;

  typedef struct packed {
    logic    in_load;
    logic    cnt_clr;
    logic    cnt_inc;
    wr_sel_e wr_sel;
    rd_sel_e rd_sel;
    cur_op_e cur_op;
    logic    out_load;
    logic    out_cell;
    logic    out_scroll;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic put_scroll;
    logic cnt_last;
    logic cnt_end;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/text_console_writer.sv =====
// throughput: one item at a time; scroll and clear
//   sweep the cell store one cell per cycle through its single write port
// reset: cursor homed, colors fg 15 / bg 0, then a clearing pass over all COLUMNS*ROWS
//   cells (2000 by default) writes blanks while s_axis_tready stays low
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: a cell store with cursor, driven by put, move,
// clear and read commands over a stream port, colors set over APB.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // cmd[1:0], char_code[9:2], pos_col[17:10], pos_row[25:18], zero fill
  input  wire logic [31:0] s_axis_tdata,

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // cursor_col_out[6:0], cursor_row_out[11:7], cell_data[27:12],
  // did_scroll[28], zero fill
  output logic [31:0]      m_axis_tdata,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [3:0] fg_q;
  logic [3:0] bg_q;
  logic       cfg_wr;

  tcw_pkg::ctrl_cmd_t ctrl_cmd;
  tcw_pkg::dp_stat_t  dp_stat;

  logic [6:0]  out_col;
  logic [4:0]  out_row;
  logic [15:0] out_cell;
  logic        out_scroll;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= tcw_pkg::FG_RESET;
      bg_q <= tcw_pkg::BG_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == tcw_pkg::REG_FG_COLOR) begin
        fg_q <= pwdata[3:0];
      end else begin
        bg_q <= pwdata[3:0];
      end
    end
  end

  assign prdata = (paddr[2] == tcw_pkg::REG_BG_COLOR) ? 32'(bg_q) : 32'(fg_q);

  tcw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .stat_i   (dp_stat),
    .cmd_o    (ctrl_cmd)
  );

  tcw_dp #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .stat_o          (dp_stat),
    .in_cmd_i        (s_axis_tdata[1:0]),
    .in_char_code_i  (s_axis_tdata[9:2]),
    .in_pos_col_i    (s_axis_tdata[17:10]),
    .in_pos_row_i    (s_axis_tdata[25:18]),
    .attr_i          ({bg_q, fg_q}),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_cursor_col_o(out_col),
    .out_cursor_row_o(out_row),
    .out_cell_data_o (out_cell),
    .out_did_scroll_o(out_scroll)
  );

  assign m_axis_tdata = {3'b000, out_scroll, out_cell, out_row, out_col};

`ifndef SYNTHESIS
  // one item at a time: a transfer in drops ready until its result is built
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  // a new result only appears after the controller has been busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a busy cycle");

  // a scroll always leaves the cursor on the last row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[28]) |-> (m_axis_tdata[11:7] == 5'(ROWS - 1)))
    else $error("scroll left cursor off the last row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata[6:0]) < COLUMNS))
    else $error("cursor column out of range");
`endif

endmodule

`default_nettype wire

// ===== sv/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller of the text console writer: sequences the reset clearing pass,
// command execution, cell read, scroll copy and screen clear.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_valid_i,
  output logic                      s_ready_o,
  input  wire tcw_pkg::dp_stat_t    stat_i,
  output tcw_pkg::ctrl_cmd_t        cmd_o
);

  tcw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    s_ready_o        = 1'b0;
    cmd_o            = '0;
    cmd_o.wr_sel     = tcw_pkg::WR_NONE;
    cmd_o.rd_sel     = tcw_pkg::RD_NONE;
    cmd_o.cur_op     = tcw_pkg::CUR_HOLD;

    unique case (state_q)
      tcw_pkg::S_INIT: begin
        cmd_o.wr_sel = tcw_pkg::WR_INIT;
        if (stat_i.cnt_last) begin
          state_d = tcw_pkg::S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end

      tcw_pkg::S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = tcw_pkg::S_EXEC;
        end
      end

      tcw_pkg::S_EXEC: begin
        unique case (stat_i.cmd)
          tcw_pkg::CMD_PUT: begin
            if (stat_i.put_scroll) begin
              cmd_o.cur_op  = tcw_pkg::CUR_PUT;
              cmd_o.wr_sel  = tcw_pkg::WR_CHAR;
              cmd_o.cnt_clr = 1'b1;
              state_d       = tcw_pkg::S_SCROLL;
            end else if (stat_i.out_free) begin
              cmd_o.cur_op   = tcw_pkg::CUR_PUT;
              cmd_o.wr_sel   = tcw_pkg::WR_CHAR;
              cmd_o.out_load = 1'b1;
              state_d        = tcw_pkg::S_IDLE;
            end
          end
          tcw_pkg::CMD_MOVE: begin
            if (stat_i.out_free) begin
              cmd_o.cur_op   = tcw_pkg::CUR_MOVE;
              cmd_o.out_load = 1'b1;
              state_d        = tcw_pkg::S_IDLE;
            end
          end
          tcw_pkg::CMD_CLEAR: begin
            cmd_o.cur_op  = tcw_pkg::CUR_HOME;
            cmd_o.cnt_clr = 1'b1;
            state_d       = tcw_pkg::S_CLEAR;
          end
          tcw_pkg::CMD_READ: begin
            cmd_o.rd_sel = tcw_pkg::RD_POS;
            state_d      = tcw_pkg::S_READ;
          end
          default: state_d = tcw_pkg::S_IDLE;
        endcase
      end

      tcw_pkg::S_READ: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_cell = 1'b1;
          state_d        = tcw_pkg::S_IDLE;
        end
      end

      tcw_pkg::S_SCROLL: begin
        // read one row ahead, write the cell behind it
        cmd_o.rd_sel = tcw_pkg::RD_COPY;
        cmd_o.wr_sel = tcw_pkg::WR_COPY;
        if (stat_i.cnt_end) begin
          if (stat_i.out_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_scroll = 1'b1;
            state_d          = tcw_pkg::S_IDLE;
          end
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end

      tcw_pkg::S_CLEAR: begin
        cmd_o.wr_sel = tcw_pkg::WR_BLANK;
        if (stat_i.cnt_last) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = tcw_pkg::S_IDLE;
          end
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end

      default: state_d = tcw_pkg::S_INIT;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/tcw_dp.sv =====
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath of the text console writer: input latch, cursor, cell store,
// sweep counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_dp #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tcw_pkg::ctrl_cmd_t cmd_i,
  output tcw_pkg::dp_stat_t       stat_o,
  input  wire logic [1:0]         in_cmd_i,
  input  wire logic [7:0]         in_char_code_i,
  input  wire logic [7:0]         in_pos_col_i,
  input  wire logic [7:0]         in_pos_row_i,
  input  wire logic [7:0]         attr_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [6:0]              out_cursor_col_o,
  output logic [4:0]              out_cursor_row_o,
  output logic [15:0]             out_cell_data_o,
  output logic                    out_did_scroll_o
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int AW1   = $clog2(CELLS + 1);
  localparam int SPLIT = CELLS - COLUMNS;

  // latched item
  tcw_pkg::cmd_e cmd_q;
  logic [7:0]    char_q;
  logic [CW-1:0] pcol_q;
  logic [RW-1:0] prow_q;

  logic [CW-1:0]  cur_col_q, cur_col_d;
  logic [RW-1:0]  cur_row_q, cur_row_d;
  logic [AW1-1:0] cnt_q, cnt_d;

  logic        out_valid_q;
  logic [6:0]  out_col_q;
  logic [4:0]  out_row_q;
  logic [15:0] out_cell_q;
  logic        out_scroll_q;

  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          is_lf, is_cr, wrap;
  logic [CW-1:0] put_col;
  logic [RW:0]   put_row;
  logic          put_scroll;

  logic [15:0]   blank, rd_data, wdata;
  logic [AW-1:0] cur_addr, pos_addr, waddr, raddr;
  logic          we, re, out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      cmd_q  <= tcw_pkg::cmd_e'(in_cmd_i);
      char_q <= in_char_code_i;
      pcol_q <= (9'(in_pos_col_i) >= 9'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(in_pos_col_i);
      prow_q <= (9'(in_pos_row_i) >= 9'(ROWS)) ? RW'(ROWS - 1) : RW'(in_pos_row_i);
    end
  end

  // cursor after a put
  always_comb begin
    is_lf   = (char_q == tcw_pkg::CODE_LF);
    is_cr   = (char_q == tcw_pkg::CODE_CR);
    col_inc = {1'b0, cur_col_q} + (CW + 1)'(1);
    row_inc = {1'b0, cur_row_q} + (RW + 1)'(1);
    wrap    = (col_inc == (CW + 1)'(COLUMNS));
    if (is_lf) begin
      put_col = '0;
      put_row = row_inc;
    end else if (is_cr) begin
      put_col = '0;
      put_row = {1'b0, cur_row_q};
    end else if (wrap) begin
      put_col = '0;
      put_row = row_inc;
    end else begin
      put_col = col_inc[CW-1:0];
      put_row = {1'b0, cur_row_q};
    end
    put_scroll = (put_row == (RW + 1)'(ROWS));
  end

  always_comb begin
    unique case (cmd_i.cur_op)
      tcw_pkg::CUR_PUT: begin
        cur_col_d = put_col;
        cur_row_d = put_scroll ? RW'(ROWS - 1) : put_row[RW-1:0];
      end
      tcw_pkg::CUR_MOVE: begin
        cur_col_d = pcol_q;
        cur_row_d = prow_q;
      end
      tcw_pkg::CUR_HOME: begin
        cur_col_d = '0;
        cur_row_d = '0;
      end
      default: begin
        cur_col_d = cur_col_q;
        cur_row_d = cur_row_q;
      end
    endcase
  end

  always_comb begin
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + AW1'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      cnt_q     <= '0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      cnt_q     <= cnt_d;
    end
  end

  // cell store addressing
  always_comb begin
    blank    = {attr_i, tcw_pkg::CODE_SPACE};
    cur_addr = AW'(AW'(cur_row_q) * AW'(COLUMNS)) + AW'(cur_col_q);
    pos_addr = AW'(AW'(prow_q) * AW'(COLUMNS)) + AW'(pcol_q);

    we    = 1'b0;
    waddr = AW'(cnt_q);
    wdata = blank;
    unique case (cmd_i.wr_sel)
      tcw_pkg::WR_CHAR: begin
        we    = !is_lf && !is_cr;
        waddr = cur_addr;
        wdata = {attr_i, char_q};
      end
      tcw_pkg::WR_INIT: begin
        we    = 1'b1;
        wdata = tcw_pkg::RESET_CELL;
      end
      tcw_pkg::WR_BLANK: begin
        we = 1'b1;
      end
      tcw_pkg::WR_COPY: begin
        // rows above the last take copied data, the last row gets blanks
        we    = (cnt_q != '0);
        waddr = AW'(cnt_q - AW1'(1));
        wdata = (cnt_q <= AW1'(SPLIT)) ? rd_data : blank;
      end
      default: we = 1'b0;
    endcase

    re    = 1'b0;
    raddr = pos_addr;
    unique case (cmd_i.rd_sel)
      tcw_pkg::RD_POS: begin
        re = 1'b1;
      end
      tcw_pkg::RD_COPY: begin
        re    = (cnt_q < AW1'(SPLIT));
        raddr = AW'(cnt_q + AW1'(COLUMNS));
      end
      default: re = 1'b0;
    endcase
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rd_data)
  );

  // result register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_col_q    <= 7'(cur_col_d);
      out_row_q    <= 5'(cur_row_d);
      out_cell_q   <= cmd_i.out_cell ? rd_data : 16'h0000;
      out_scroll_q <= cmd_i.out_scroll;
    end
  end

  assign stat_o.cmd        = cmd_q;
  assign stat_o.put_scroll = put_scroll;
  assign stat_o.cnt_last   = (cnt_q == AW1'(CELLS - 1));
  assign stat_o.cnt_end    = (cnt_q == AW1'(CELLS));
  assign stat_o.out_free   = out_free;

  assign out_valid_o      = out_valid_q;
  assign out_cursor_col_o = out_col_q;
  assign out_cursor_row_o = out_row_q;
  assign out_cell_data_o  = out_cell_q;
  assign out_did_scroll_o = out_scroll_q;

endmodule

`default_nettype wire

// ===== verif/text_console_writer_checker.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_checker
// Watches the command stream, the status stream and the APB color writes of
// the console writer, keeps its own copy of the cell store and the cursor,
// and compares every status transfer with the oldest predicted status.
// ----------------------------------------------------------------------------
module text_console_writer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,

  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,

  output int          fail_count_o,
  output int          results_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOLS  = tcw_pkg::COLUMNS_DEF;
  localparam int NROWS  = tcw_pkg::ROWS_DEF;
  localparam int NCELLS = NCOLS * NROWS;

  // same layout as m_axis_tdata[28:0]
  typedef struct packed {
    logic        did_scroll;
    logic [15:0] cell_data;
    logic [4:0]  row;
    logic [6:0]  col;
  } status_t;

  logic [15:0] screen [NCELLS];
  logic [6:0]  cur_col;
  logic [4:0]  cur_row;
  logic [3:0]  fg_color;
  logic [3:0]  bg_color;
  status_t     due_status_q [$];
  int          fails = 0;

  task report_mismatch(input string what, input int got, input int want);
    fails++;
    $display("%0t console status mismatch: %s got %0h want %0h", $realtime, what, got,
             want);
  endtask

  function logic [15:0] glyph(input logic [7:0] ch);
    return {bg_color, fg_color, ch};
  endfunction

  function status_t console_step(input logic [31:0] word);
    tcw_pkg::cmd_e op;
    logic [7:0]    ch;
    int            col;
    int            row;
    int            at;
    status_t       st;
    op  = tcw_pkg::cmd_e'(word[1:0]);
    ch  = word[9:2];
    col = (int'(word[17:10]) >= NCOLS) ? NCOLS - 1 : int'(word[17:10]);
    row = (int'(word[25:18]) >= NROWS) ? NROWS - 1 : int'(word[25:18]);
    st  = '0;
    case (op)
      tcw_pkg::CMD_PUT: begin
        if (ch == tcw_pkg::CODE_LF) begin
          cur_col = '0;
          cur_row = cur_row + 5'd1;
        end else if (ch == tcw_pkg::CODE_CR) begin
          cur_col = '0;
        end else begin
          screen[int'(cur_row) * NCOLS + int'(cur_col)] = glyph(ch);
          if (int'(cur_col) == NCOLS - 1) begin
            cur_col = '0;
            cur_row = cur_row + 5'd1;
          end else begin
            cur_col = cur_col + 7'd1;
          end
        end
        // running off the bottom shifts everything up one row
        if (int'(cur_row) >= NROWS) begin
          for (at = 0; at < NCELLS - NCOLS; at++) screen[at] = screen[at + NCOLS];
          for (at = NCELLS - NCOLS; at < NCELLS; at++) begin
            screen[at] = glyph(tcw_pkg::CODE_SPACE);
          end
          cur_row       = 5'(NROWS - 1);
          st.did_scroll = 1'b1;
        end
      end
      tcw_pkg::CMD_MOVE: begin
        cur_col = 7'(col);
        cur_row = 5'(row);
      end
      tcw_pkg::CMD_CLEAR: begin
        for (at = 0; at < NCELLS; at++) screen[at] = glyph(tcw_pkg::CODE_SPACE);
        cur_col = '0;
        cur_row = '0;
      end
      default: begin
        st.cell_data = screen[row * NCOLS + col];
      end
    endcase
    st.col = cur_col;
    st.row = cur_row;
    return st;
  endfunction

  always @(posedge clk_i) begin
    status_t got;
    status_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NCELLS; i++) screen[i] = tcw_pkg::RESET_CELL;
      cur_col  = '0;
      cur_row  = '0;
      fg_color = tcw_pkg::FG_RESET;
      bg_color = tcw_pkg::BG_RESET;
      due_status_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == tcw_pkg::REG_FG_COLOR) fg_color = pwdata[3:0];
        else bg_color = pwdata[3:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[28:0];
        if (due_status_q.size() == 0) begin
          report_mismatch("status with none due", int'(got), 0);
        end else begin
          want = due_status_q.pop_front();
          if (got.col != want.col) report_mismatch("cursor col", got.col, want.col);
          if (got.row != want.row) report_mismatch("cursor row", got.row, want.row);
          if (got.cell_data != want.cell_data)
            report_mismatch("cell data", got.cell_data, want.cell_data);
          if (got.did_scroll != want.did_scroll)
            report_mismatch("scroll flag", got.did_scroll, want.did_scroll);
        end
      end
      if (s_axis_tvalid && s_axis_tready) due_status_q.push_back(console_step(s_axis_tdata));
    end
    results_due_o <= due_status_q.size();
    fail_count_o  <= fails;
  end

endmodule

// ===== verif/text_console_writer_test.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_test
// Drives put, move, clear and read commands into the console writer with
// random gaps and back-pressure, changes colors over APB between phases, and
// reports the verdict of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module text_console_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // cmd[1:0], char_code[9:2], pos_col[17:10], pos_row[25:18], zero fill
  logic [31:0] s_axis_tdata = '0;

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // cursor_col_out[6:0], cursor_row_out[11:7], cell_data[27:12],
  // did_scroll[28], zero fill
  logic [31:0] m_axis_tdata;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          results_due;

  bit          rx_idle_on = 1'b1;
  int          hold_ask = 0;

  text_console_writer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  text_console_writer_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .results_due_o (results_due)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // worst case is every item scrolling, plus the long hold-off, several times over
  initial begin
    #40ms;
    $display("text_console_writer_test: FAIL");
    $finish;
  end

  function automatic logic [31:0] pack_op(input tcw_pkg::cmd_e op, input logic [7:0] ch,
                                          input logic [7:0] col, input logic [7:0] row);
    return {6'b0, row, col, ch, op};
  endfunction

  function automatic logic [31:0] random_op();
    int            r;
    tcw_pkg::cmd_e op;
    logic [7:0]    ch;
    logic [7:0]    col;
    logic [7:0]    row;
    ch  = 8'($urandom_range(0, 255));
    col = 8'($urandom_range(0, 255));
    row = 8'($urandom_range(0, 255));
    r   = $urandom_range(0, 99);
    if (r < 1) begin
      op = tcw_pkg::CMD_CLEAR;
    end else if (r < 16) begin
      op = tcw_pkg::CMD_MOVE;
      r  = $urandom_range(0, 99);
      if (r < 75) col = 8'($urandom_range(0, tcw_pkg::COLUMNS_DEF - 1));
      else if (r < 90) col = 8'(tcw_pkg::COLUMNS_DEF - 1);
      r = $urandom_range(0, 99);
      // the last row is favored so that puts run into scrolls
      if (r < 65) row = 8'($urandom_range(0, tcw_pkg::ROWS_DEF - 1));
      else if (r < 85) row = 8'(tcw_pkg::ROWS_DEF - 1);
    end else if (r < 40) begin
      op = tcw_pkg::CMD_READ;
      if ($urandom_range(0, 1) == 0) begin
        col = 8'($urandom_range(0, tcw_pkg::COLUMNS_DEF - 1));
        row = 8'($urandom_range(tcw_pkg::ROWS_DEF - 5, tcw_pkg::ROWS_DEF - 1));
      end
    end else begin
      op = tcw_pkg::CMD_PUT;
      r  = $urandom_range(0, 99);
      if (r < 6) ch = tcw_pkg::CODE_LF;
      else if (r < 10) ch = tcw_pkg::CODE_CR;
    end
    return pack_op(op, ch, col, row);
  endfunction

  task automatic push_op(input logic [31:0] word);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic reg_sel, input logic [3:0] color);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {28'($urandom), color};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // receiver: random ready bursts, and one long hold-off on request
  initial begin
    int holds_done;
    holds_done = 0;
    @(posedge clk_i);
    forever begin
      if (hold_ask != holds_done) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        holds_done++;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [31:0] ops [$];
    logic [3:0]  fg_val;
    logic [3:0]  bg_val;
    bit          tx_idle;
    tx_idle = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ops = '{
      pack_op(tcw_pkg::CMD_PUT,   8'h41,            8'hFF,  8'hFF),
      pack_op(tcw_pkg::CMD_READ,  8'hFF,            8'd0,   8'd0),
      pack_op(tcw_pkg::CMD_READ,  8'h00,            8'd200, 8'hFF),
      pack_op(tcw_pkg::CMD_MOVE,  8'h5A,            8'hFF,  8'hFF),
      // last cell: wrap and scroll
      pack_op(tcw_pkg::CMD_PUT,   8'hFF,            8'd0,   8'd0),
      pack_op(tcw_pkg::CMD_READ,  8'h00,            8'd79,  8'd23),
      // line feed on last row scrolls
      pack_op(tcw_pkg::CMD_PUT,   tcw_pkg::CODE_LF, 8'd0,   8'd0),
      pack_op(tcw_pkg::CMD_READ,  8'h00,            8'd79,  8'd22),
      pack_op(tcw_pkg::CMD_PUT,   8'h42,            8'd0,   8'd0),
      pack_op(tcw_pkg::CMD_PUT,   tcw_pkg::CODE_CR, 8'd0,   8'd0),
      pack_op(tcw_pkg::CMD_PUT,   8'h00,            8'd0,   8'd0),
      pack_op(tcw_pkg::CMD_MOVE,  8'h00,            8'd80,  8'd25),
      pack_op(tcw_pkg::CMD_MOVE,  8'h00,            8'd79,  8'd0),
      // wrap without scroll
      pack_op(tcw_pkg::CMD_PUT,   8'h7A,            8'd0,   8'd0),
      pack_op(tcw_pkg::CMD_PUT,   tcw_pkg::CODE_LF, 8'd0,   8'd0),
      pack_op(tcw_pkg::CMD_READ,  8'h00,            8'd0,   8'd24),
      pack_op(tcw_pkg::CMD_READ,  8'h00,            8'd1,   8'd24),
      pack_op(tcw_pkg::CMD_CLEAR, 8'hFF,            8'hFF,  8'hFF),
      pack_op(tcw_pkg::CMD_READ,  8'h00,            8'd0,   8'd24),
      pack_op(tcw_pkg::CMD_MOVE,  8'h00,            8'd78,  8'd24),
      pack_op(tcw_pkg::CMD_PUT,   8'h78,            8'd0,   8'd0),
      pack_op(tcw_pkg::CMD_PUT,   8'h79,            8'd0,   8'd0),
      pack_op(tcw_pkg::CMD_READ,  8'h00,            8'd78,  8'd23),
      pack_op(tcw_pkg::CMD_READ,  8'h00,            8'hFF,  8'd0)
    };
    foreach (ops[i]) push_op(ops[i]);

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      repeat (4) @(posedge clk_i);
      case (ph)
        0: begin fg_val = 4'h0; bg_val = 4'hF; end
        1: begin fg_val = 4'hF; bg_val = 4'h0; end
        2: begin fg_val = 4'h0; bg_val = 4'h0; end
        3: begin fg_val = 4'hF; bg_val = 4'hF; end
        default: begin
          fg_val = 4'($urandom_range(0, 15));
          bg_val = 4'($urandom_range(0, 15));
        end
      endcase
      apb_write(tcw_pkg::REG_FG_COLOR, fg_val);
      apb_write(tcw_pkg::REG_BG_COLOR, bg_val);
      for (int n = 0; n < 225; n++) begin
        if (n % 40 == 0) begin
          // the last phase runs with no idling on either side
          tx_idle    = (ph != 5) && ($urandom_range(0, 2) != 0);
          rx_idle_on <= (ph != 5) && ($urandom_range(0, 2) != 0);
        end
        if (ph == 1 && n == 60) hold_ask <= hold_ask + 1;
        if (ph == 2 && n == 100) wait_drained();
        if (tx_idle && $urandom_range(0, 4) == 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 13)) @(posedge clk_i);
        end
        push_op(random_op());
      end
    end

    wait_drained();
    repeat (tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF + 100) @(posedge clk_i);
    if (fail_count == 0 && results_due == 0) begin
      $display("text_console_writer_test: PASS");
    end else begin
      $display("text_console_writer_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_ctrl.sv
sv/tcw_dp.sv
sv/text_console_writer.sv
verif/text_console_writer_checker.sv
verif/text_console_writer_test.sv
